[sv/ssd_pkg.sv]
`timescale 1ns / 1ps

package ssd_pkg;

    // Field widths of the item and result beats.
    localparam int COMMAND_BITS = 3;
    localparam int NUMBER_BITS  = 16;
    localparam int ANODE_LINES  = 4;
    localparam int SEG_LINES    = 7;

    // Default geometry of the display.
    localparam int DEF_DIGIT_COUNT   = 4;
    localparam int DEF_SEGMENT_COUNT = 7;

    // Decimal conversion covers four digits of a value up to this limit.
    localparam int DEC_DIGITS    = 4;
    localparam int VALUE_BITS    = 14;
    localparam int NUMBER_LIMIT  = 9999;
    localparam int PROD_BITS     = 28;
    // floor(x * RECIP >> SHIFT) equals floor(x / 10^k) for every x up to the limit.
    localparam int TENS_RECIP    = 6554;
    localparam int TENS_SHIFT    = 16;
    localparam int HUND_RECIP    = 5243;
    localparam int HUND_SHIFT    = 19;
    localparam int THOU_RECIP    = 8389;
    localparam int THOU_SHIFT    = 23;

    typedef enum logic [COMMAND_BITS-1:0] {
        CMD_TICK   = 3'd0,
        CMD_NUMBER = 3'd1,
        CMD_OPEN   = 3'd2,
        CMD_DONE   = 3'd3,
        CMD_EMPTY  = 3'd4
    } command_t;

    // Character codes held in the digit store.
    localparam logic [3:0] CODE_ZERO  = 4'd0;
    localparam logic [3:0] CODE_BLANK = 4'd10;
    localparam logic [3:0] CODE_O     = 4'd11;
    localparam logic [3:0] CODE_P     = 4'd12;
    localparam logic [3:0] CODE_E     = 4'd13;
    localparam logic [3:0] CODE_N     = 4'd14;
    localparam logic [3:0] CODE_D     = 4'd15;

    typedef struct packed {
        logic                  in_range;
        logic [VALUE_BITS-1:0] value;
        logic [9:0]            tens;
        logic [6:0]            hundreds;
        logic [3:0]            thousands;
    } number_prep_t;

    typedef struct packed {
        command_t     command;
        number_prep_t num;
    } stage_beat_t;

    // Segment pattern of a character, segments a..g in bits 0..6; bit 7 is never lit.
    function automatic logic [7:0] glyph(input logic [3:0] code);
        logic [7:0] pattern;
        unique case (code)
            4'd0:    pattern = 8'h3F;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5B;
            4'd3:    pattern = 8'h4F;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'h7D;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7F;
            4'd9:    pattern = 8'h6F;
            4'd10:   pattern = 8'h00;
            4'd11:   pattern = 8'h5C;
            4'd12:   pattern = 8'h73;
            4'd13:   pattern = 8'h79;
            4'd14:   pattern = 8'h54;
            default: pattern = 8'h5E;
        endcase
        return pattern;
    endfunction

    // Character for store entry idx (entry 0 is the rightmost digit) of a fixed word.
    function automatic logic [3:0] word_code(input command_t cmd, input int idx);
        logic [3:0] code;
        code = CODE_BLANK;
        if (idx < DEC_DIGITS) begin
            unique case (cmd)
                CMD_OPEN:
                begin
                    unique case (idx)
                        0:       code = CODE_N;
                        1:       code = CODE_E;
                        2:       code = CODE_P;
                        default: code = CODE_O;
                    endcase
                end
                CMD_DONE:
                begin
                    unique case (idx)
                        0:       code = CODE_E;
                        1:       code = CODE_N;
                        2:       code = CODE_O;
                        default: code = CODE_D;
                    endcase
                end
                default: code = CODE_BLANK;
            endcase
        end
        return code;
    endfunction

endpackage

[sv/seven_segment_scan_driver_top.sv]
`timescale 1ns / 1ps

// Multiplexed seven-segment driver that lights a single segment of a single
// digit at a time. Each input beat carries a command: tick steps the scan to
// the next segment place (digit-major, wrapping after the last segment of the
// last digit), set number loads 0..9999 as decimal digits with leading zeros
// (larger values are ignored), and set open, set done and set empty load the
// words "oPEn", "donE" or blanks. Every input beat yields exactly one output
// beat carrying the anode lines (active high, at most one set, bit 0 is the leftmost
// digit) and the cathode lines (segments a..g, active low) as they stand after
// the command; commands other than tick leave the lines unchanged. After reset
// the display holds 0000 with all lines off. The block takes one beat per
// clock: an input register feeds a result register, which presents the
// result beat of an item; throughput is limited only by output backpressure.
module seven_segment_scan_driver_top
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT   = DEF_DIGIT_COUNT,
    parameter int SEGMENT_COUNT = DEF_SEGMENT_COUNT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COMMAND_BITS-1:0] command,
    input  logic [NUMBER_BITS-1:0]  number,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ANODE_LINES-1:0]  anode_drive,
    output logic [SEG_LINES-1:0]    cathode_drive
);

    logic        stage_valid;
    logic        stage_ready;
    stage_beat_t stage_beat;

    ssd_input_stage u_input_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .number      (number),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage_beat  (stage_beat)
    );

    ssd_display_core #(
        .DIGIT_COUNT   (DIGIT_COUNT),
        .SEGMENT_COUNT (SEGMENT_COUNT)
    ) u_display_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage_valid   (stage_valid),
        .stage_ready   (stage_ready),
        .stage_beat    (stage_beat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .anode_drive   (anode_drive),
        .cathode_drive (cathode_drive)
    );

endmodule

[sv/ssd_input_stage.sv]
`timescale 1ns / 1ps

module ssd_input_stage
    import ssd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COMMAND_BITS-1:0] command,
    input  logic [NUMBER_BITS-1:0]  number,
    output logic                    stage_valid,
    input  logic                    stage_ready,
    output stage_beat_t             stage_beat
);

    logic                  valid_reg;
    logic                  valid_next;
    stage_beat_t           beat_reg;
    stage_beat_t           beat_next;
    logic [VALUE_BITS-1:0] value;
    logic [PROD_BITS-1:0]  prod_tens;
    logic [PROD_BITS-1:0]  prod_hund;
    logic [PROD_BITS-1:0]  prod_thou;

    assign in_ready    = !valid_reg || stage_ready;
    assign stage_valid = valid_reg;
    assign stage_beat  = beat_reg;

    // The quotients by 10, 100 and 1000 are formed in parallel here, so that the
    // next stage only has small subtractions left to split out the digits.
    assign value     = number[VALUE_BITS-1:0];
    assign prod_tens = PROD_BITS'(value) * PROD_BITS'(TENS_RECIP);
    assign prod_hund = PROD_BITS'(value) * PROD_BITS'(HUND_RECIP);
    assign prod_thou = PROD_BITS'(value) * PROD_BITS'(THOU_RECIP);

    always_comb
    begin
        beat_next                  = beat_reg;
        valid_next                 = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next                 = 1'b1;
            beat_next.command          = command_t'(command);
            beat_next.num.in_range     = (number <= NUMBER_BITS'(NUMBER_LIMIT));
            beat_next.num.value        = value;
            beat_next.num.tens         = prod_tens[TENS_SHIFT +: 10];
            beat_next.num.hundreds     = prod_hund[HUND_SHIFT +: 7];
            beat_next.num.thousands    = prod_thou[THOU_SHIFT +: 4];
        end
        else if (stage_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

endmodule

[sv/ssd_display_core.sv]
`timescale 1ns / 1ps

module ssd_display_core
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT   = DEF_DIGIT_COUNT,
    parameter int SEGMENT_COUNT = DEF_SEGMENT_COUNT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   stage_valid,
    output logic                   stage_ready,
    input  stage_beat_t            stage_beat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ANODE_LINES-1:0] anode_drive,
    output logic [SEG_LINES-1:0]   cathode_drive
);

    localparam int DIGIT_BITS = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int SEG_BITS   = $clog2(SEGMENT_COUNT);

    logic                   fire;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [DIGIT_BITS-1:0]  digit_reg;
    logic [DIGIT_BITS-1:0]  digit_next;
    logic [SEG_BITS-1:0]    seg_reg;
    logic [SEG_BITS-1:0]    seg_next;
    logic [3:0]             codes_reg [DIGIT_COUNT];
    logic [3:0]             codes_next [DIGIT_COUNT];
    logic [ANODE_LINES-1:0] anode_reg;
    logic [ANODE_LINES-1:0] anode_next;
    logic [SEG_LINES-1:0]   cathode_reg;
    logic [SEG_LINES-1:0]   cathode_next;
    logic [3:0]             dec_digit [DEC_DIGITS];
    logic [DIGIT_BITS-1:0]  store_index;
    logic [7:0]             pattern;
    logic                   lit;

    // The result register doubles as the drive-line state, so a stalled
    // result beat holds simply because nothing advances.
    assign stage_ready   = !out_valid_reg || out_ready;
    assign fire          = stage_valid && stage_ready;
    assign out_valid     = out_valid_reg;
    assign anode_drive   = anode_reg;
    assign cathode_drive = cathode_reg;

    assign dec_digit[0] = 4'(stage_beat.num.value
                             - VALUE_BITS'(stage_beat.num.tens) * VALUE_BITS'(10));
    assign dec_digit[1] = 4'(stage_beat.num.tens - 10'(stage_beat.num.hundreds) * 10'd10);
    assign dec_digit[2] = 4'(stage_beat.num.hundreds - 7'(stage_beat.num.thousands) * 7'd10);
    assign dec_digit[3] = stage_beat.num.thousands;

    // Next scan place, kept as digit and segment so no division is needed.
    always_comb
    begin
        seg_next   = seg_reg + SEG_BITS'(1);
        digit_next = digit_reg;
        if (seg_reg == SEG_BITS'(SEGMENT_COUNT - 1))
        begin
            seg_next = '0;
            if (digit_reg == DIGIT_BITS'(DIGIT_COUNT - 1))
            begin
                digit_next = '0;
            end
            else
            begin
                digit_next = digit_reg + DIGIT_BITS'(1);
            end
        end
    end

    // The leftmost digit shows the most significant store entry.
    assign store_index = DIGIT_BITS'(DIGIT_COUNT - 1) - digit_next;
    assign pattern     = glyph(codes_reg[store_index]);
    assign lit         = pattern[seg_next[2:0]];

    always_comb
    begin
        anode_next     = anode_reg;
        cathode_next   = cathode_reg;
        codes_next     = codes_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next = 1'b1;
            unique case (stage_beat.command)
                CMD_TICK:
                begin
                    for (int i = 0; i < ANODE_LINES; i++)
                    begin
                        anode_next[i] = lit && (32'(digit_next) == i);
                    end
                    for (int j = 0; j < SEG_LINES; j++)
                    begin
                        cathode_next[j] = !(lit && (32'(seg_next) == j));
                    end
                end
                CMD_NUMBER:
                begin
                    if (stage_beat.num.in_range)
                    begin
                        for (int i = 0; i < DIGIT_COUNT; i++)
                        begin
                            codes_next[i] = (i < DEC_DIGITS) ? dec_digit[i % DEC_DIGITS]
                                                             : CODE_ZERO;
                        end
                    end
                end
                CMD_OPEN, CMD_DONE, CMD_EMPTY:
                begin
                    for (int i = 0; i < DIGIT_COUNT; i++)
                    begin
                        codes_next[i] = word_code(stage_beat.command, i);
                    end
                end
                default:
                begin
                    codes_next = codes_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            digit_reg     <= '0;
            seg_reg       <= '0;
            anode_reg     <= '0;
            cathode_reg   <= '1;
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                codes_reg[i] <= CODE_ZERO;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            anode_reg     <= anode_next;
            cathode_reg   <= cathode_next;
            codes_reg     <= codes_next;
            if (fire && (stage_beat.command == CMD_TICK))
            begin
                digit_reg <= digit_next;
                seg_reg   <= seg_next;
            end
        end
    end

endmodule
